### src/edq_pkg.sv
// Shared types and constants for the edge/delay condition qualifier.
`timescale 1ns / 1ps

package edq_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS = 1'd1;

    localparam logic [1:0] EDGE_LEVEL   = 2'd0;
    localparam logic [1:0] EDGE_RISING  = 2'd1;
    localparam logic [1:0] EDGE_FALLING = 2'd2;
    localparam logic [1:0] EDGE_EITHER  = 2'd3;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic result;
        logic history_overflow;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              value;
    } hist_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

### src/edge_delay_condition_qualifier.sv
// Top level: edge qualification plus time-delayed sample history with sequential scan.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one request per evaluation, {level, sample_time}; sample_time
//   must not decrease. m_ channel: one {result, history_overflow} per request.
//   cfg_wen/cfg_index/cfg_wdata: write edge_mode (index 0) or delay_ticks
//   (index 1) while no request is in flight.
// Result paths
//   delay_ticks == 0 or sample_time < delay_ticks: result registered in the cycle after accept.
//   Otherwise the history ring is scanned from the oldest entry, one entry per
//   cycle through the single registered memory read port (a READ state, then
//   one CHECK state per entry examined, up to HISTORY_DEPTH entries).
//   s_ready is low during the scan, so no new request is taken until it ends.
// Reset
//   aresetn (sync, low) clears state, config, m_valid, edge history flag and ring
//   head/count; memory contents and datapath/result data registers are not cleared.
// Stall
//   The result register holds while m_ready is low; a new request is taken only
//   once the pending result leaves (or leaves in the same cycle).
module edge_delay_condition_qualifier #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [edq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [edq_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  edq_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output edq_pkg::out_item_t              m_data
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(HISTORY_DEPTH - 1);

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W+1)'(HISTORY_DEPTH)) begin
            sum = sum - (IDX_W+1)'(HISTORY_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    edq_pkg::hist_entry_t hist_mem [HISTORY_DEPTH];
    edq_pkg::hist_entry_t rd_data_reg;

    edq_pkg::state_t state_reg, state_next;

    logic [1:0]                  edge_mode_reg;
    logic [edq_pkg::TIME_W-1:0]  delay_reg;
    logic                        prior_reg, has_prior_reg;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [edq_pkg::TIME_W-1:0]  target_reg;
    logic                        ovf_reg, ovf_next;
    logic [IDX_W-1:0]            chk_idx_reg, chk_idx_next;
    logic                        sel_found_reg, sel_found_next;
    logic [IDX_W-1:0]            sel_idx_reg, sel_idx_next;
    logic                        sel_val_reg, sel_val_next;
    logic                        m_valid_reg, m_valid_next;
    edq_pkg::out_item_t          m_data_reg, m_data_next;

    logic                 accept;
    logic                 edge_val;
    logic                 delay_zero;
    logic                 before_delay;
    logic                 full;
    logic [IDX_W-1:0]     head_push;
    logic [CNT_W-1:0]     count_push;
    logic [IDX_W-1:0]     wr_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 pass;
    logic [CNT_W-1:0]     next_cnt;
    logic                 scan_more;
    logic                 fin_found;
    logic [IDX_W-1:0]     fin_idx;
    logic                 fin_val;

    assign s_ready = (state_reg == edq_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign delay_zero   = (delay_reg == '0);
    assign before_delay = (s_data.sample_time < delay_reg);

    always_comb begin
        case (edge_mode_reg)
            edq_pkg::EDGE_LEVEL:   edge_val = s_data.level;
            edq_pkg::EDGE_RISING:  edge_val = has_prior_reg && s_data.level && !prior_reg;
            edq_pkg::EDGE_FALLING: edge_val = has_prior_reg && !s_data.level && prior_reg;
            edq_pkg::EDGE_EITHER:  edge_val = has_prior_reg && (s_data.level != prior_reg);
            default:               edge_val = 1'b0;
        endcase
    end

    // push position, dropping the oldest entry when the ring is full
    assign full       = (count_reg == DEPTH_CNT);
    assign head_push  = full ? ring_add(head_reg, IDX_W'(1)) : head_reg;
    assign count_push = full ? DEPTH_M1 : count_reg;
    assign wr_addr    = ring_add(head_push, count_push[IDX_W-1:0]);
    assign wr_en      = accept && !delay_zero;

    // scan step
    assign pass      = (rd_data_reg.stamp <= target_reg);
    assign next_cnt  = CNT_W'(chk_idx_reg) + CNT_W'(1);
    assign scan_more = pass && (next_cnt < count_reg);
    assign fin_found = sel_found_reg || pass;
    assign fin_idx   = pass ? chk_idx_reg : sel_idx_reg;
    assign fin_val   = pass ? rd_data_reg.value : sel_val_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            edq_pkg::ST_IDLE: begin
                if (accept && !delay_zero && !before_delay) begin
                    state_next = edq_pkg::ST_READ;
                end
            end
            edq_pkg::ST_READ: begin
                state_next = edq_pkg::ST_CHECK;
            end
            edq_pkg::ST_CHECK: begin
                if (!scan_more) begin
                    state_next = edq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = edq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        chk_idx_next   = chk_idx_reg;
        sel_found_next = sel_found_reg;
        sel_idx_next   = sel_idx_reg;
        sel_val_next   = sel_val_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        rd_addr        = head_reg;
        case (state_reg)
            edq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (delay_zero) begin
                        m_valid_next                = 1'b1;
                        m_data_next.result          = edge_val;
                        m_data_next.history_overflow = 1'b0;
                    end else begin
                        head_next      = head_push;
                        count_next     = count_push + CNT_W'(1);
                        ovf_next       = full;
                        chk_idx_next   = '0;
                        sel_found_next = 1'b0;
                        sel_idx_next   = '0;
                        sel_val_next   = 1'b0;
                        if (before_delay) begin
                            m_valid_next                = 1'b1;
                            m_data_next.result          = 1'b0;
                            m_data_next.history_overflow = full;
                        end
                    end
                end
            end
            edq_pkg::ST_READ: begin
                rd_addr = head_reg;
            end
            edq_pkg::ST_CHECK: begin
                if (scan_more) begin
                    rd_addr        = ring_add(head_reg, next_cnt[IDX_W-1:0]);
                    chk_idx_next   = next_cnt[IDX_W-1:0];
                    sel_found_next = 1'b1;
                    sel_idx_next   = chk_idx_reg;
                    sel_val_next   = rd_data_reg.value;
                end else begin
                    m_valid_next                = 1'b1;
                    m_data_next.result          = fin_found && fin_val;
                    m_data_next.history_overflow = ovf_reg;
                    if (fin_found) begin
                        head_next  = ring_add(head_reg, fin_idx);
                        count_next = count_reg - CNT_W'(fin_idx);
                    end
                end
            end
            default: begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= edq_pkg::ST_IDLE;
            edge_mode_reg <= edq_pkg::EDGE_LEVEL;
            delay_reg     <= '0;
            prior_reg     <= 1'b0;
            has_prior_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                prior_reg     <= s_data.level;
                has_prior_reg <= 1'b1;
            end
            if (cfg_wen) begin
                case (cfg_index)
                    edq_pkg::REG_EDGE_MODE:   edge_mode_reg <= cfg_wdata[1:0];
                    edq_pkg::REG_DELAY_TICKS: delay_reg     <= cfg_wdata[edq_pkg::TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg       <= ovf_next;
        chk_idx_reg   <= chk_idx_next;
        sel_found_reg <= sel_found_next;
        sel_idx_reg   <= sel_idx_next;
        sel_val_reg   <= sel_val_next;
        m_data_reg    <= m_data_next;
        if (accept) begin
            target_reg <= s_data.sample_time - delay_reg;
        end
    end

    // history ring
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= '{stamp: s_data.sample_time, value: edge_val};
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

endmodule

### src/edq_checker.sv
// Port-level checks for the edge/delay condition qualifier, bound to the top level.
`timescale 1ns / 1ps

module edq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wen,
    input logic [edq_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [edq_pkg::CFG_W-1:0]     cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input edq_pkg::out_item_t            m_data
);

    logic delay_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_zero_reg <= 1'b1;
        end else if (cfg_wen && (cfg_index == edq_pkg::REG_DELAY_TICKS)) begin
            delay_zero_reg <= (cfg_wdata == '0);
        end
    end

    // a request is only taken when the result register is free or draining
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("request accepted while result stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // bypass path: result next cycle, never an overflow
    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && delay_zero_reg) |=> (m_valid && !m_data.history_overflow))
        else $error("zero-delay request did not complete in one cycle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind edge_delay_condition_qualifier edq_checker u_edq_checker (.*);
